// ----- src/annexb_to_length_prefix_nal_defines.svh -----
// ----------------------------------------------------------------------------
// Annex B converter assertion macros
// Shared assertion forms for the stream checker, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ANNEXB_TO_LENGTH_PREFIX_NAL_DEFINES_SVH
`define ANNEXB_TO_LENGTH_PREFIX_NAL_DEFINES_SVH

// same-cycle implication
`define ANNEXB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ANNEXB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/annexb_pkg.sv -----
// ----------------------------------------------------------------------------
// Annex B converter package
// Widths, codes and constants shared by the converter and its checker.
// ----------------------------------------------------------------------------
package annexb_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 24;
    localparam int TYPE_W          = 5;
    localparam int PAY_CNT_W       = 3;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_TDATA_W     = 40;

    localparam logic [LEN_W-1:0]  OUT_LEN_MAX = 24'hFF_FFFF;
    localparam logic [BYTE_W-1:0] START_BYTE  = 8'h01;
    localparam logic [1:0]        ZERO_RUN    = 2'd3;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_RECORD  = 1'b1
    } t_kind;

endpackage

// ----- src/annexb_to_length_prefix_nal.sv -----
// ----------------------------------------------------------------------------
// Annex B to length-prefixed NAL converter
// Strips 00 00 00 01 start codes from a byte stream, passes payload bytes
// and emits a length/type record per closed unit.
// ----------------------------------------------------------------------------
// A byte is registered in the input skid register, then its words in the result countdown registers.
// Throughput: one byte per cycle while each byte yields at most one word and the output is
// not stalled; a byte yielding n words (up to 5) holds the result countdown until all n are taken.
// Input skid register frees the slave side while a result word waits.
// Reset: synchronous, active low; clears the stream state and all queued work.
module annexb_to_length_prefix_nal #(
    parameter int LENGTH_BITS = annexb_pkg::LENGTH_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [7:0] data_byte
    input  logic [annexb_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [7:0] out_byte, [31:8] unit_length, [36:32] unit_type,
    // [37] length_saturated, [39:38] zero
    output logic [annexb_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                               o_m_axis_tlast,
    // [0] out_kind
    output logic [0:0]                         o_m_axis_tuser
);

    localparam int EXT_W = 33;

    // input skid register
    logic                             r_in_valid;
    logic [annexb_pkg::BYTE_W-1:0]    r_in_byte;
    logic                             r_in_last;

    // stream state
    logic [1:0]                       r_held_zeros, n_held_zeros;
    logic                             r_unit_open, n_unit_open;
    logic [LENGTH_BITS-1:0]           r_byte_count, n_byte_count;
    logic [annexb_pkg::TYPE_W-1:0]    r_header_type, n_header_type;
    logic                             r_count_overflow, n_count_overflow;

    // result countdown: payload words first, then at most one record
    logic [annexb_pkg::PAY_CNT_W-1:0] r_pay_cnt, n_pay_cnt;
    logic [annexb_pkg::BYTE_W-1:0]    r_pay_byte, n_pay_byte;
    logic                             r_rec_valid, n_rec_valid;
    logic [annexb_pkg::LEN_W-1:0]     r_rec_len, n_rec_len;
    logic [annexb_pkg::TYPE_W-1:0]    r_rec_type, n_rec_type;
    logic                             r_rec_sat, n_rec_sat;

    logic                             plan_empty;
    logic                             plan_last;
    logic                             plan_free;
    logic                             advance;
    logic                             out_fire;

    // single-pass work signals
    logic                             b_zero;
    logic                             is_sc;
    logic                             case_c;
    logic [1:0]                       hz1;
    logic [annexb_pkg::PAY_CNT_W-1:0] p1;
    logic [annexb_pkg::PAY_CNT_W-1:0] p2;
    logic [annexb_pkg::PAY_CNT_W-1:0] pay;
    logic                             open_b;
    logic [LENGTH_BITS-1:0]           c0;
    logic [annexb_pkg::TYPE_W-1:0]    t0;
    logic                             o0;
    logic [annexb_pkg::BYTE_W-1:0]    first_byte;
    logic [LENGTH_BITS:0]             sum;
    logic [LENGTH_BITS-1:0]           c1;
    logic [annexb_pkg::TYPE_W-1:0]    t1;
    logic                             o1;
    logic                             open1;
    logic                             pre_rec;
    logic                             post_rec;
    logic [LENGTH_BITS-1:0]           rec_cnt;
    logic                             rec_ovf;
    logic [EXT_W-1:0]                 rec_ext;
    logic                             rec_clamp;

    annexb_pkg::t_kind                out_kind;

    assign plan_empty = (r_pay_cnt == '0) && !r_rec_valid;
    assign plan_last  = ((r_pay_cnt == annexb_pkg::PAY_CNT_W'(1)) && !r_rec_valid)
                      || ((r_pay_cnt == '0) && r_rec_valid);
    assign plan_free  = plan_empty || (plan_last && i_m_axis_tready);
    assign advance    = r_in_valid && plan_free;
    assign out_fire   = o_m_axis_tvalid && i_m_axis_tready;

    assign o_s_axis_tready = !r_in_valid || plan_free;

    always_comb begin
        b_zero = (r_in_byte == '0);
        is_sc  = (r_in_byte == annexb_pkg::START_BYTE)
              && (r_held_zeros == annexb_pkg::ZERO_RUN);
        case_c = !b_zero && !is_sc;

        // hold zeros up to three; a fourth pushes the oldest out as payload
        if (b_zero) begin
            hz1 = (r_held_zeros == annexb_pkg::ZERO_RUN) ? annexb_pkg::ZERO_RUN
                                                          : r_held_zeros + 2'd1;
        end else begin
            hz1 = '0;
        end

        priority if (b_zero && (r_held_zeros == annexb_pkg::ZERO_RUN)) begin
            p1 = annexb_pkg::PAY_CNT_W'(1);
        end else if (case_c) begin
            p1 = annexb_pkg::PAY_CNT_W'(r_held_zeros) + annexb_pkg::PAY_CNT_W'(1);
        end else begin
            p1 = '0;
        end
        p2  = r_in_last ? annexb_pkg::PAY_CNT_W'(hz1) : '0;
        pay = p1 + p2;

        // a start code opens a fresh, empty unit
        open_b = r_unit_open || is_sc;
        c0     = is_sc ? '0 : r_byte_count;
        t0     = is_sc ? '0 : r_header_type;
        o0     = is_sc ? 1'b0 : r_count_overflow;
        if ((pay != '0) && !open_b) begin
            c0 = '0;
            t0 = '0;
            o0 = 1'b0;
        end

        first_byte = (case_c && (r_held_zeros == '0)) ? r_in_byte : '0;
        t1 = ((pay != '0) && (c0 == '0) && !o0)
           ? first_byte[annexb_pkg::TYPE_W-1:0] : t0;

        // saturate the count at all ones
        sum   = {1'b0, c0} + (LENGTH_BITS+1)'(pay);
        c1    = sum[LENGTH_BITS] ? '1 : sum[LENGTH_BITS-1:0];
        o1    = o0 || sum[LENGTH_BITS];
        open1 = open_b || (pay != '0);

        pre_rec  = is_sc && r_unit_open;
        post_rec = r_in_last && open1 && ((c1 != '0) || o1);

        rec_cnt   = pre_rec ? r_byte_count : c1;
        rec_ovf   = pre_rec ? r_count_overflow : o1;
        rec_ext   = EXT_W'(rec_cnt);
        rec_clamp = rec_ext > EXT_W'(annexb_pkg::OUT_LEN_MAX);

        n_held_zeros     = r_held_zeros;
        n_unit_open      = r_unit_open;
        n_byte_count     = r_byte_count;
        n_header_type    = r_header_type;
        n_count_overflow = r_count_overflow;
        n_pay_cnt        = r_pay_cnt;
        n_pay_byte       = r_pay_byte;
        n_rec_valid      = r_rec_valid;
        n_rec_len        = r_rec_len;
        n_rec_type       = r_rec_type;
        n_rec_sat        = r_rec_sat;

        if (advance) begin
            if (r_in_last) begin
                n_held_zeros     = '0;
                n_unit_open      = 1'b0;
                n_byte_count     = '0;
                n_header_type    = '0;
                n_count_overflow = 1'b0;
            end else begin
                n_held_zeros     = hz1;
                n_unit_open      = open1;
                n_byte_count     = c1;
                n_header_type    = t1;
                n_count_overflow = o1;
            end
            n_pay_cnt   = pay;
            n_pay_byte  = case_c ? r_in_byte : '0;
            n_rec_valid = pre_rec || post_rec;
            n_rec_len   = rec_clamp ? annexb_pkg::OUT_LEN_MAX
                                    : rec_ext[annexb_pkg::LEN_W-1:0];
            n_rec_type  = pre_rec ? r_header_type : t1;
            n_rec_sat   = rec_ovf || rec_clamp;
        end else if (out_fire) begin
            // drain payload words, then the record
            if (r_pay_cnt != '0) begin
                n_pay_cnt = r_pay_cnt - annexb_pkg::PAY_CNT_W'(1);
            end else begin
                n_rec_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_held_zeros     <= '0;
            r_unit_open      <= 1'b0;
            r_byte_count     <= '0;
            r_header_type    <= '0;
            r_count_overflow <= 1'b0;
            r_pay_cnt        <= '0;
            r_rec_valid      <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            r_held_zeros     <= n_held_zeros;
            r_unit_open      <= n_unit_open;
            r_byte_count     <= n_byte_count;
            r_header_type    <= n_header_type;
            r_count_overflow <= n_count_overflow;
            r_pay_cnt        <= n_pay_cnt;
            r_rec_valid      <= n_rec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata[annexb_pkg::BYTE_W-1:0];
            r_in_last <= i_s_axis_tlast;
        end
        r_pay_byte <= n_pay_byte;
        r_rec_len  <= n_rec_len;
        r_rec_type <= n_rec_type;
        r_rec_sat  <= n_rec_sat;
    end

    always_comb begin
        o_m_axis_tvalid = !plan_empty;
        if (r_pay_cnt != '0) begin
            out_kind       = annexb_pkg::KIND_PAYLOAD;
            o_m_axis_tlast = (r_pay_cnt == annexb_pkg::PAY_CNT_W'(1)) && !r_rec_valid;
            // only the final payload word can carry a non-zero byte
            o_m_axis_tdata = annexb_pkg::OUT_TDATA_W'(
                (r_pay_cnt == annexb_pkg::PAY_CNT_W'(1)) ? r_pay_byte : '0);
        end else begin
            out_kind       = annexb_pkg::KIND_RECORD;
            o_m_axis_tlast = 1'b1;
            o_m_axis_tdata = {2'b00, r_rec_sat, r_rec_type, r_rec_len,
                              {annexb_pkg::BYTE_W{1'b0}}};
        end
        o_m_axis_tuser = out_kind;
    end

endmodule

// ----- src/annexb_chk.sv -----
// ----------------------------------------------------------------------------
// Annex B converter port checker
// Watches the converter's stream ports; bound into the converter module.
// ----------------------------------------------------------------------------
`include "annexb_to_length_prefix_nal_defines.svh"

module annexb_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_axis_tvalid,
    input logic                               o_s_axis_tready,
    input logic [annexb_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                               i_s_axis_tlast,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [annexb_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                               o_m_axis_tlast,
    input logic [0:0]                         o_m_axis_tuser
);

    logic rec_word;
    logic pay_word;

    assign rec_word = o_m_axis_tvalid && (o_m_axis_tuser[0] == annexb_pkg::KIND_RECORD);
    assign pay_word = o_m_axis_tvalid && (o_m_axis_tuser[0] == annexb_pkg::KIND_PAYLOAD);

    // a stalled word holds
    `ANNEXB_ASSERT_NEXT(a_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser), "stalled output word changed")

    // a record closes the results of its byte
    `ANNEXB_ASSERT_NOW(a_rec_last, rec_word, o_m_axis_tlast, "record word without tlast")

    `ANNEXB_ASSERT_NOW(a_rec_clean, rec_word, (o_m_axis_tdata[7:0] == 8'h00) && (o_m_axis_tdata[39:38] == 2'b00), "record word with payload bits set")

    `ANNEXB_ASSERT_NOW(a_pay_clean, pay_word, o_m_axis_tdata[39:8] == 32'h0, "payload word with record bits set")

    // a record word is never taken without tlast; it is always the last of its byte's results
    `ANNEXB_ASSERT_NEXT(a_rec_pair, rec_word && i_m_axis_tready && !o_m_axis_tlast, 1'b0, "record word not last of its byte")

endmodule

bind annexb_to_length_prefix_nal annexb_chk u_annexb_chk (.*);
